### sv/rmf_pkg.sv
// Shared constants and types for the running median filter.
package rmf_pkg;

  localparam int DEF_WINDOW       = 9;
  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int MEDIAN_WIDTH     = 32;
  localparam int FILL_WIDTH       = 4;

  // Movement of a cell's entry toward its neighbors on an update
  typedef struct packed {
    logic up;
    logic down;
  } rmf_move_t;

endpackage

### sv/rmf_cell.sv
// One cell of the sorted window: holds a sample, its age and a valid flag.
module rmf_cell
  import rmf_pkg::*;
#(
  parameter int WINDOW       = DEF_WINDOW,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int AGE_WIDTH    = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           restart,
  input  logic                           full,
  input  logic                           head,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  logic        [AGE_WIDTH-1:0]    left_age,
  input  logic                           left_valid,
  input  rmf_move_t                      left_move,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  logic        [AGE_WIDTH-1:0]    right_age,
  input  rmf_move_t                      right_move,
  input  logic                           del_in,
  output logic                           del_out,
  output rmf_move_t                      move,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic        [AGE_WIDTH-1:0]    age,
  output logic                           valid
);

  localparam logic [AGE_WIDTH-1:0] OLDEST = AGE_WIDTH'(WINDOW - 1);

  logic                           del;
  logic                           keep;
  logic                           lt;
  logic                           stay;
  logic signed [SAMPLE_WIDTH-1:0] val_next;
  logic        [AGE_WIDTH-1:0]    age_next;
  logic                           valid_next;

  always_comb begin
    del       = full & valid & (age == OLDEST);
    keep      = valid & ~del & ~restart;
    lt        = keep & (val < x);
    move.up   = keep & ~lt & ~del_in;
    move.down = keep & lt & del_in;
    stay      = keep & (lt ^ del_in);
    del_out   = del_in | del;

    if (left_move.up) begin
      val_next = left_val;
      age_next = left_age + AGE_WIDTH'(1);
    end else if (stay) begin
      val_next = val;
      age_next = age + AGE_WIDTH'(1);
    end else if (right_move.down) begin
      val_next = right_val;
      age_next = right_age + AGE_WIDTH'(1);
    end else begin
      val_next = x;
      age_next = '0;
    end

    if (restart) begin
      valid_next = head;
    end else if (full) begin
      valid_next = valid;
    end else begin
      valid_next = valid | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

### sv/running_median_filter.sv
// Top level of the running median filter: sorted cell row and result register.
//
//   channel | signals                              | direction
//   in      | in_valid, in_stall, sample, restart  | item in, stall out
//   out     | out_valid, out_stall, median,        | item out, stall in
//           | fill_count, window_full              |
//
// One item per cycle sustained while the output is not stalled; an accepted item sets pend,
// and out_valid rises when it advances. The cell row inserts the new sample and drops
// the oldest in the accept cycle; the middle cell is then picked into the output register.
// Reset clears the valid flags, the count and both valid stages.
// A stalled output still lets one more item into the cell row before in_stall rises.
module running_median_filter
  import rmf_pkg::*;
#(
  parameter int WINDOW       = DEF_WINDOW,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic        [SAMPLE_WIDTH-1:0] sample,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [MEDIAN_WIDTH-1:0] median,
  output logic        [FILL_WIDTH-1:0]   fill_count,
  output logic                           window_full
);

  localparam int AGE_WIDTH   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_WIDTH = $clog2(WINDOW + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(WINDOW);

  logic                           accept;
  logic                           advance;
  logic                           pend;
  logic                           full;
  logic [COUNT_WIDTH-1:0]         count;
  logic [COUNT_WIDTH-1:0]         count_next;
  logic [COUNT_WIDTH-1:0]         mid;
  logic [SAMPLE_WIDTH-1:0]        sel;
  logic [SAMPLE_WIDTH+MEDIAN_WIDTH-1:0] sel_ext;
  logic [COUNT_WIDTH+FILL_WIDTH-1:0]    count_ext;

  logic signed [SAMPLE_WIDTH-1:0] cell_val   [WINDOW];
  logic        [AGE_WIDTH-1:0]    cell_age   [WINDOW];
  logic                           cell_valid [WINDOW];
  rmf_move_t                      cell_move  [WINDOW];
  logic                           del_chain  [WINDOW+1];

  assign advance  = pend & (~out_valid | ~out_stall);
  assign in_stall = pend & ~advance;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count == COUNT_MAX) & ~restart;
  assign del_chain[0] = 1'b0;

  always_comb begin
    if (restart) begin
      count_next = COUNT_WIDTH'(1);
    end else if (count == COUNT_MAX) begin
      count_next = count;
    end else begin
      count_next = count + COUNT_WIDTH'(1);
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] lval;
    logic        [AGE_WIDTH-1:0]    lage;
    logic                           lvalid;
    rmf_move_t                      lmove;
    logic signed [SAMPLE_WIDTH-1:0] rval;
    logic        [AGE_WIDTH-1:0]    rage;
    rmf_move_t                      rmove;

    if (i == 0) begin : g_head
      assign lval   = '0;
      assign lage   = '0;
      assign lvalid = 1'b1;
      assign lmove  = '0;
    end else begin : g_body
      assign lval   = cell_val[i-1];
      assign lage   = cell_age[i-1];
      assign lvalid = cell_valid[i-1];
      assign lmove  = cell_move[i-1];
    end

    if (i == WINDOW - 1) begin : g_tail
      assign rval  = '0;
      assign rage  = '0;
      assign rmove = '0;
    end else begin : g_inner
      assign rval  = cell_val[i+1];
      assign rage  = cell_age[i+1];
      assign rmove = cell_move[i+1];
    end

    rmf_cell #(
      .WINDOW       (WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_WIDTH    (AGE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (accept),
      .restart    (restart),
      .full       (full),
      .head       (i == 0),
      .x          (sample),
      .left_val   (lval),
      .left_age   (lage),
      .left_valid (lvalid),
      .left_move  (lmove),
      .right_val  (rval),
      .right_age  (rage),
      .right_move (rmove),
      .del_in     (del_chain[i]),
      .del_out    (del_chain[i+1]),
      .move       (cell_move[i]),
      .val        (cell_val[i]),
      .age        (cell_age[i]),
      .valid      (cell_valid[i])
    );
  end

  assign mid = count >> 1;

  always_comb begin
    sel = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (mid == COUNT_WIDTH'(i)) begin
        sel = cell_val[i];
      end
    end
    sel_ext   = (SAMPLE_WIDTH + MEDIAN_WIDTH)'(sel);
    count_ext = (COUNT_WIDTH + FILL_WIDTH)'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      median      <= sel_ext[MEDIAN_WIDTH-1:0];
      fill_count  <= count_ext[FILL_WIDTH-1:0];
      window_full <= (count == COUNT_MAX);
    end
  end

endmodule

### sv/rmf_checker.sv
// Port-level checks for the running median filter, bound to the top level.
module rmf_checker
  import rmf_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [MEDIAN_WIDTH-1:0] median,
  input logic        [FILL_WIDTH-1:0]   fill_count,
  input logic                           window_full
);

  localparam logic [FILL_WIDTH-1:0] FILL_MAX = FILL_WIDTH'(WINDOW);

  a_stall_needs_blocked_out: assert property (
    @(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall)
  ) else $error("input stalled while output is free");

  a_fill_nonzero: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && WINDOW < 16) |-> (fill_count != '0)
  ) else $error("empty window reported");

  a_full_matches_count: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && WINDOW < 16) |-> (window_full == (fill_count == FILL_MAX))
  ) else $error("window_full disagrees with fill_count");

  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(median) && $stable(fill_count))
  ) else $error("stalled output item changed");

endmodule

bind running_median_filter rmf_checker #(
  .WINDOW (WINDOW)
) u_rmf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .median      (median),
  .fill_count  (fill_count),
  .window_full (window_full)
);

### tb/running_median_filter_tb.sv
// Self-checking testbench for running_median_filter: directed and random sample streams.
module running_median_filter_tb;
  import rmf_pkg::*;

  localparam int WINDOW       = DEF_WINDOW;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [MEDIAN_WIDTH-1:0] median;
    logic [FILL_WIDTH-1:0]          fill_count;
    logic                           window_full;
  } median_result_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [DEF_SAMPLE_WIDTH-1:0]     sample;
  logic                            restart;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [MEDIAN_WIDTH-1:0]  median;
  logic [FILL_WIDTH-1:0]           fill_count;
  logic                            window_full;

  // samples held by the predictor, oldest first
  logic signed [31:0] window_samples[$];
  median_result_t     pending_medians[$];
  median_result_t     head_result;
  int                 errors = 0;
  int                 cycles = 0;

  // long receiver hold requested by the test sequence, served by the receiver
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int phase_left    = 0;
  int stall_pct     = 0;

  running_median_filter #(
    .WINDOW      (WINDOW),
    .SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .median     (median),
    .fill_count (fill_count),
    .window_full(window_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // push one accepted item into the predictor window and queue its median
  function automatic void track_sample(input logic signed [31:0] s, input logic r);
    median_result_t res;
    int             count;
    int             rank;
    int             less;
    int             same;
    if (r)
      window_samples.delete();
    if (window_samples.size() == WINDOW)
      void'(window_samples.pop_front());
    window_samples.push_back(s);
    count = window_samples.size();
    rank = count / 2 + 1;
    res.median = '0;
    for (int i = 0; i < count; i++) begin
      less = 0;
      same = 0;
      for (int j = 0; j < count; j++) begin
        if (window_samples[j] < window_samples[i])
          less++;
        else if (window_samples[j] == window_samples[i])
          same++;
      end
      if (less < rank && rank <= less + same) begin
        res.median = window_samples[i];
        break;
      end
    end
    res.fill_count = count[FILL_WIDTH-1:0];
    res.window_full = (count == WINDOW);
    pending_medians.push_back(res);
  endfunction

  function automatic logic signed [31:0] random_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2: return int'($urandom_range(0, 10)) - 5;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic signed [31:0] s, input logic r);
    @(negedge clk);
    in_valid <= 1'b1;
    sample <= s;
    restart <= r;
    do @(posedge clk); while (in_stall);
    track_sample(s, r);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (pending_medians.size() != 0)
      @(posedge clk);
  endtask

  // receiver: long holds on request, otherwise random stall phases
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 100);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end else begin
        phase_left = phase_left - 1;
      end
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected item: median %0d fill %0d full %0d",
                 $time, median, fill_count, window_full);
        errors++;
      end else begin
        head_result = pending_medians.pop_front();
        if (median !== head_result.median) begin
          $display("%0t: median mismatch: expected %0d, got %0d",
                   $time, head_result.median, median);
          errors++;
        end
        if (fill_count !== head_result.fill_count) begin
          $display("%0t: fill_count mismatch: expected %0d, got %0d",
                   $time, head_result.fill_count, fill_count);
          errors++;
        end
        if (window_full !== head_result.window_full) begin
          $display("%0t: window_full mismatch: expected %0d, got %0d",
                   $time, head_result.window_full, window_full);
          errors++;
        end
      end
    end
  end

  // warm-up with extremes: even fills give the upper median, then eviction
  task automatic test_warmup_extremes();
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(S_MAX, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(S_MIN, 1'b0);
  endtask

  task automatic test_duplicates();
    send_item(32'sd5, 1'b1);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd0, 1'b0);
  endtask

  // restart in the middle of a window and twice in a row
  task automatic test_restart();
    send_item(S_MIN, 1'b1);
    send_item(32'sd7, 1'b0);
    send_item(S_MAX, 1'b1);
    send_item(-32'sd9, 1'b1);
    send_item(32'sd4, 1'b0);
    send_item(-32'sd1, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    hold_requests++;
    for (int n = 0; n < 30; n++)
      send_item(random_sample(), 1'b0);
    drain_results();
  endtask

  task automatic test_random_stream();
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0)
          idle_cycles($urandom_range(1, 6));
      end
      send_item(random_sample(), $urandom_range(0, 19) == 0);
      burst_left--;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    restart = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_warmup_extremes();
    test_duplicates();
    test_restart();
    test_backpressure();
    test_random_stream();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_medians.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, pending_medians.size());
      errors++;
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### running_median_filter.f
sv/rmf_pkg.sv
sv/rmf_cell.sv
sv/running_median_filter.sv
sv/rmf_checker.sv
tb/running_median_filter_tb.sv
